### rtl/core/assert_macros.svh
// concurrent assertion helpers, all sampled on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds in every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/ntt_pkg.sv
package ntt_pkg;

   localparam int MAX_TARGETS = 16;
   localparam int COORD_BITS  = 12;
   localparam int IDX_BITS    = $clog2(MAX_TARGETS);
   localparam int CNT_BITS    = $clog2(MAX_TARGETS + 1);
   localparam int SLOT_BITS   = IDX_BITS + 1;
   localparam int BANK_DEPTH  = 2 * MAX_TARGETS;
   localparam int SQ_BITS     = 2 * COORD_BITS;
   localparam int DIST_BITS   = 2 * COORD_BITS + 1;
   localparam int DIR_BITS    = 2;

   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + DIR_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = IDX_BITS + 2 * COORD_BITS + CNT_BITS + 1;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic {
      OP_POINT = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [DIST_BITS-1:0]  dist_type;

   localparam logic signed [DIR_BITS-1:0] DIR_RIGHT = 2'sb01;

   typedef struct packed {
      opcode_type                   opcode;
      coord_type                    pos_x;
      coord_type                    pos_y;
      logic                         frame_end;
      logic signed [DIR_BITS-1:0]   step_dir;
   } item_type;

   typedef struct packed {
      logic      overflow;
      cnt_type   target_count;
      coord_type sel_y;
      coord_type sel_x;
      idx_type   sel_index;
   } result_type;

endpackage

### rtl/core/nearest_target_tracker_unit.sv
// Nearest-target tracker. Takes one request per clock unless stalled: a detection point
// (tuser low) or a selection step (tuser high). Points of a frame are stored in a spare
// bank of 16 slots while the point nearest the current selection (squared distance,
// earliest wins a tie) is tracked; the point marked with tlast commits the bank and moves
// the selection to that nearest point, or to point 0 when no list was held. Further points
// of a full frame are dropped and reported through overflow. Steps move the selection one
// slot left or right, clamped to the list, or leave it in place. A point with tlast and
// every step give one response; other points give none. Throughput is one request per
// cycle while the input is not stalled; a request is held in the input register, and its
// response (distance, compare, bank write or bank read) is computed from there and appears
// from the result register. The response register stalls the input side only when a
// response is held and not taken.
`include "assert_macros.svh"

module nearest_target_tracker_unit
   import ntt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pos_x [11:0], pos_y [23:12], step_dir [25:24], zero fill above
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // opcode
   input  logic                      req_tuser,
   // frame_end
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // sel_index [3:0], sel_x [15:4], sel_y [27:16], target_count [32:28],
   // overflow [33], zero fill above
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata
);

   // input register
   logic        item_valid_ff, item_valid_in;
   item_type    item_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   // tracker state
   coord_type   bank_x_ff [BANK_DEPTH];
   coord_type   bank_y_ff [BANK_DEPTH];
   logic        live_bank_ff, live_bank_in;
   cnt_type     live_count_ff, live_count_in;
   cnt_type     fill_count_ff, fill_count_in;
   idx_type     chosen_idx_ff, chosen_idx_in;
   coord_type   chosen_px_ff, chosen_px_in;
   coord_type   chosen_py_ff, chosen_py_in;
   dist_type    best_dist_ff, best_dist_in;
   idx_type     best_idx_ff, best_idx_in;
   coord_type   best_x_ff, best_x_in;
   coord_type   best_y_ff, best_y_in;
   coord_type   first_x_ff, first_x_in;
   coord_type   first_y_ff, first_y_in;
   logic        dropped_ff, dropped_in;
   logic        committed_drop_ff, committed_drop_in;

   logic        req_accept;
   logic        has_rsp;
   logic        fire;
   logic        stored;
   logic        closer;
   logic        bank_wr_en;
   logic [SLOT_BITS-1:0] bank_wr_slot;
   logic [SLOT_BITS-1:0] step_slot;
   idx_type     step_idx;
   dist_type    point_dist;
   item_type    req_item;

   assign req_item.opcode    = opcode_type'(req_tuser);
   assign req_item.pos_x     = req_tdata[COORD_BITS-1:0];
   assign req_item.pos_y     = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign req_item.frame_end = req_tlast;
   assign req_item.step_dir  = req_tdata[2*COORD_BITS+DIR_BITS-1:2*COORD_BITS];

   assign has_rsp    = (item_ff.opcode == OP_STEP) || item_ff.frame_end;
   assign fire       = item_valid_ff && (!has_rsp || !rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_data_ff);

   ntt_sqdist u_sqdist (
      .pos_x  (item_ff.pos_x),
      .pos_y  (item_ff.pos_y),
      .ref_x  (chosen_px_ff),
      .ref_y  (chosen_py_ff),
      .sq_sum (point_dist)
   );

   assign stored       = fill_count_ff < CNT_BITS'(MAX_TARGETS);
   assign closer       = point_dist < best_dist_ff;
   assign bank_wr_en   = fire && (item_ff.opcode == OP_POINT) && stored;
   assign bank_wr_slot = {~live_bank_ff, fill_count_ff[IDX_BITS-1:0]};

   // clamped step index within the live list
   always_comb begin
      step_idx = chosen_idx_ff;
      if (item_ff.step_dir == DIR_RIGHT) begin
         if ((CNT_BITS'(chosen_idx_ff) + CNT_BITS'(1)) < live_count_ff) begin
            step_idx = chosen_idx_ff + IDX_BITS'(1);
         end
      end else if (item_ff.step_dir[DIR_BITS-1]) begin
         if (chosen_idx_ff != '0) begin
            step_idx = chosen_idx_ff - IDX_BITS'(1);
         end
      end
   end

   assign step_slot = {live_bank_ff, step_idx};

   always_comb begin
      item_valid_in     = item_valid_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_data_in       = rsp_data_ff;
      live_bank_in      = live_bank_ff;
      live_count_in     = live_count_ff;
      fill_count_in     = fill_count_ff;
      chosen_idx_in     = chosen_idx_ff;
      chosen_px_in      = chosen_px_ff;
      chosen_py_in      = chosen_py_ff;
      best_dist_in      = best_dist_ff;
      best_idx_in       = best_idx_ff;
      best_x_in         = best_x_ff;
      best_y_in         = best_y_ff;
      first_x_in        = first_x_ff;
      first_y_in        = first_y_ff;
      dropped_in        = dropped_ff;
      committed_drop_in = committed_drop_ff;

      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (fire) begin
         if (item_ff.opcode == OP_STEP) begin
            rsp_valid_in = 1'b1;
            if (live_count_ff == '0) begin
               rsp_data_in = '0;
            end else begin
               chosen_idx_in = step_idx;
               chosen_px_in  = bank_x_ff[step_slot];
               chosen_py_in  = bank_y_ff[step_slot];
               rsp_data_in.sel_index    = step_idx;
               rsp_data_in.sel_x        = bank_x_ff[step_slot];
               rsp_data_in.sel_y        = bank_y_ff[step_slot];
               rsp_data_in.target_count = live_count_ff;
               rsp_data_in.overflow     = committed_drop_ff;
            end
         end else begin
            if (stored) begin
               fill_count_in = fill_count_ff + CNT_BITS'(1);
               if (closer) begin
                  best_dist_in = point_dist;
                  best_idx_in  = fill_count_ff[IDX_BITS-1:0];
                  best_x_in    = item_ff.pos_x;
                  best_y_in    = item_ff.pos_y;
               end
               if (fill_count_ff == '0) begin
                  first_x_in = item_ff.pos_x;
                  first_y_in = item_ff.pos_y;
               end
            end else begin
               dropped_in = 1'b1;
            end

            if (item_ff.frame_end) begin
               // no list held before: selection falls back to point 0
               if (live_count_ff == '0) begin
                  chosen_idx_in = '0;
                  chosen_px_in  = first_x_in;
                  chosen_py_in  = first_y_in;
               end else begin
                  chosen_idx_in = best_idx_in;
                  chosen_px_in  = best_x_in;
                  chosen_py_in  = best_y_in;
               end
               live_bank_in      = ~live_bank_ff;
               live_count_in     = fill_count_in;
               committed_drop_in = dropped_in;
               fill_count_in     = '0;
               best_dist_in      = '1;
               best_idx_in       = '0;
               dropped_in        = 1'b0;
               rsp_valid_in      = 1'b1;
               rsp_data_in.sel_index    = chosen_idx_in;
               rsp_data_in.sel_x        = chosen_px_in;
               rsp_data_in.sel_y        = chosen_py_in;
               rsp_data_in.target_count = live_count_in;
               rsp_data_in.overflow     = committed_drop_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         live_bank_ff      <= 1'b0;
         live_count_ff     <= '0;
         fill_count_ff     <= '0;
         chosen_idx_ff     <= '0;
         chosen_px_ff      <= '0;
         chosen_py_ff      <= '0;
         best_dist_ff      <= '1;
         best_idx_ff       <= '0;
         dropped_ff        <= 1'b0;
         committed_drop_ff <= 1'b0;
      end else begin
         item_valid_ff     <= item_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         live_bank_ff      <= live_bank_in;
         live_count_ff     <= live_count_in;
         fill_count_ff     <= fill_count_in;
         chosen_idx_ff     <= chosen_idx_in;
         chosen_px_ff      <= chosen_px_in;
         chosen_py_ff      <= chosen_py_in;
         best_dist_ff      <= best_dist_in;
         best_idx_ff       <= best_idx_in;
         dropped_ff        <= dropped_in;
         committed_drop_ff <= committed_drop_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_item;
      end
      rsp_data_ff <= rsp_data_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      if (bank_wr_en) begin
         bank_x_ff[bank_wr_slot] <= item_ff.pos_x;
         bank_y_ff[bank_wr_slot] <= item_ff.pos_y;
      end
   end

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_count_ff <= CNT_BITS'(MAX_TARGETS), "fill count past capacity")
   `ASSERT_IMPLIES(a_sel_in_list, clock, reset, live_count_ff != '0, CNT_BITS'(chosen_idx_ff) < live_count_ff, "selection outside live list")
   `ASSERT_IMPLIES(a_drop_when_full, clock, reset, dropped_ff, fill_count_ff == CNT_BITS'(MAX_TARGETS), "drop flagged below capacity")
   `ASSERT_IMPLIES(a_best_idle, clock, reset, fill_count_ff == '0, best_dist_ff == '1, "running minimum not cleared")
   `ASSERT_NEXT(a_commit_clears, clock, reset, fire && item_ff.opcode == OP_POINT && item_ff.frame_end, fill_count_ff == '0 && live_count_ff != '0 && rsp_valid_ff, "frame commit incomplete")

endmodule

### rtl/core/ntt_sqdist.sv
module ntt_sqdist
   import ntt_pkg::*;
(
   input  coord_type pos_x,
   input  coord_type pos_y,
   input  coord_type ref_x,
   input  coord_type ref_y,
   output dist_type  sq_sum
);

   coord_type           dx;
   coord_type           dy;
   logic [SQ_BITS-1:0]  sq_x;
   logic [SQ_BITS-1:0]  sq_y;

   assign dx     = (pos_x > ref_x) ? (pos_x - ref_x) : (ref_x - pos_x);
   assign dy     = (pos_y > ref_y) ? (pos_y - ref_y) : (ref_y - pos_y);
   assign sq_x   = SQ_BITS'(dx) * SQ_BITS'(dx);
   assign sq_y   = SQ_BITS'(dy) * SQ_BITS'(dy);
   assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};

endmodule

### bench/ntt_checker.sv
module ntt_checker
   import ntt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                      req_tuser,
   input  logic                      req_tlast,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   coord_type  pos_x_bank [BANK_DEPTH];
   coord_type  pos_y_bank [BANK_DEPTH];
   int         live_bank;
   int         live_count;
   int         fill_count;
   int         chosen_idx;
   coord_type  chosen_x;
   coord_type  chosen_y;
   dist_type   nearest_dist;
   int         nearest_idx;
   logic       dropped_now;
   logic       dropped_committed;
   result_type expected_selections [$];

   function automatic result_type selection_now();
      result_type sel;
      sel.sel_index    = idx_type'(chosen_idx);
      sel.sel_x        = chosen_x;
      sel.sel_y        = chosen_y;
      sel.target_count = cnt_type'(live_count);
      sel.overflow     = dropped_committed;
      return sel;
   endfunction

   task automatic queue_selection(input result_type sel);
      expected_selections.insert(expected_selections.size(), sel);
   endtask

   task automatic load_chosen();
      int slot;
      slot     = live_bank * MAX_TARGETS + (chosen_idx % MAX_TARGETS);
      chosen_x = pos_x_bank[slot];
      chosen_y = pos_y_bank[slot];
   endtask

   task automatic track_request(input item_type req);
      dist_type dx;
      dist_type dy;
      dist_type sq_sum;
      int       spare;
      if (req.opcode == OP_STEP) begin
         if (live_count == 0) begin
            queue_selection(result_type'(0));
         end else begin
            if (req.step_dir == DIR_RIGHT) begin
               if (chosen_idx + 1 < live_count) chosen_idx++;
            end else if (req.step_dir[1]) begin
               if (chosen_idx > 0) chosen_idx--;
            end
            load_chosen();
            queue_selection(selection_now());
         end
      end else begin
         spare = live_bank ^ 1;
         if (fill_count < MAX_TARGETS) begin
            dx     = (req.pos_x > chosen_x) ? req.pos_x - chosen_x : chosen_x - req.pos_x;
            dy     = (req.pos_y > chosen_y) ? req.pos_y - chosen_y : chosen_y - req.pos_y;
            sq_sum = dx * dx + dy * dy;
            pos_x_bank[spare * MAX_TARGETS + fill_count] = req.pos_x;
            pos_y_bank[spare * MAX_TARGETS + fill_count] = req.pos_y;
            // strict compare keeps the earliest point on a tie
            if (sq_sum < nearest_dist) begin
               nearest_dist = sq_sum;
               nearest_idx  = fill_count;
            end
            fill_count++;
         end else begin
            dropped_now = 1'b1;
         end
         if (req.frame_end) begin
            chosen_idx        = (live_count == 0) ? 0 : nearest_idx;
            live_bank         = spare;
            live_count        = fill_count;
            dropped_committed = dropped_now;
            load_chosen();
            fill_count   = 0;
            nearest_dist = '1;
            nearest_idx  = 0;
            dropped_now  = 1'b0;
            queue_selection(selection_now());
         end
      end
   endtask

   always @(posedge clock) begin
      item_type   req;
      result_type got;
      result_type want;
      if (reset) begin
         live_bank         = 0;
         live_count        = 0;
         fill_count        = 0;
         chosen_idx        = 0;
         chosen_x          = '0;
         chosen_y          = '0;
         nearest_dist      = '1;
         nearest_idx       = 0;
         dropped_now       = 1'b0;
         dropped_committed = 1'b0;
         fail_count        = 0;
         expected_selections.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
            if (expected_selections.size() == 0) begin
               $error("response with no request waiting for it");
               fail_count++;
            end else begin
               want = expected_selections.pop_front();
               if (got.sel_index !== want.sel_index) begin
                  $error("sel_index expected %0d got %0d", want.sel_index, got.sel_index);
                  fail_count++;
               end
               if (got.sel_x !== want.sel_x) begin
                  $error("sel_x expected %0d got %0d", want.sel_x, got.sel_x);
                  fail_count++;
               end
               if (got.sel_y !== want.sel_y) begin
                  $error("sel_y expected %0d got %0d", want.sel_y, got.sel_y);
                  fail_count++;
               end
               if (got.target_count !== want.target_count) begin
                  $error("target_count expected %0d got %0d",
                         want.target_count, got.target_count);
                  fail_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $error("overflow expected %0d got %0d", want.overflow, got.overflow);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req.opcode    = opcode_type'(req_tuser);
            req.pos_x     = req_tdata[COORD_BITS-1:0];
            req.pos_y     = req_tdata[2*COORD_BITS-1:COORD_BITS];
            req.frame_end = req_tlast;
            req.step_dir  = req_tdata[2*COORD_BITS+DIR_BITS-1:2*COORD_BITS];
            track_request(req);
         end
      end
      pending <= expected_selections.size();
   end

endmodule

### bench/tb_top.sv
module tb_top;
   import ntt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1950;
   localparam int IDLE_LIMIT   = 500;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tuser;
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   int                       fail_count;
   int                       pending;
   int                       idle_cycles;
   int                       sent;
   bit                       calm;

   nearest_target_tracker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ntt_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 3))
         0: return coord_type'($urandom_range(0, 4095));
         1: return $urandom_range(0, 1) ? coord_type'(4095) : coord_type'(0);
         // tight clusters give many equal distances
         2: return coord_type'($urandom_range(0, 15));
         default: return coord_type'($urandom_range(2040, 2056));
      endcase
   endfunction

   function automatic logic signed [DIR_BITS-1:0] rand_dir();
      return DIR_BITS'($urandom_range(0, 3));
   endfunction

   task automatic push_request(input opcode_type op, input coord_type x, input coord_type y,
                               input logic last, input logic signed [DIR_BITS-1:0] dir);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tlast  <= last;
      req_tdata  <= REQ_DATA_BITS'({dir, y, x});
      do @(posedge clock); while (!req_tready);
      sent++;
      if ($urandom_range(0, 63) == 0) calm = ~calm;
   endtask

   task automatic point(input coord_type x, input coord_type y, input logic last);
      push_request(OP_POINT, x, y, last, rand_dir());
   endtask

   task automatic step(input logic signed [DIR_BITS-1:0] dir);
      push_request(OP_STEP, coord_type'($urandom), coord_type'($urandom),
                   logic'($urandom_range(0, 1)), dir);
   endtask

   // response side stalls independently
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         gap = calm ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int goal;
      int len;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      reset      = 1'b1;
      sent       = 0;
      calm       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // steps on an empty list
      step(2'sb01);
      step(2'sb11);
      step(2'sb10);
      step(2'sb00);
      // first frame overfills the bank, last point is dropped
      point(12'd0, 12'd0, 1'b0);
      point(12'd4095, 12'd4095, 1'b0);
      point(12'd0, 12'd4095, 1'b0);
      point(12'd4095, 12'd0, 1'b0);
      point(12'd7, 12'd7, 1'b0);
      point(12'd7, 12'd7, 1'b0);
      repeat (10) point(rand_coord(), rand_coord(), 1'b0);
      point(12'd4095, 12'd4095, 1'b1);
      // walk the selection and clamp at the left end
      step(2'sb01);
      step(2'sb11);
      step(2'sb10);
      step(2'sb00);
      // equal points, the earlier one wins
      point(12'd5, 12'd5, 1'b0);
      point(12'd5, 12'd5, 1'b0);
      point(12'd4095, 12'd4095, 1'b1);
      // clamp at the right end
      step(2'sb01);
      step(2'sb01);
      step(2'sb01);
      // step in the middle of a frame
      point(12'd10, 12'd10, 1'b0);
      step(2'sb11);
      point(12'd20, 12'd20, 1'b1);

      goal = sent + RANDOM_ITEMS;
      while (sent < goal) begin
         repeat ($urandom_range(0, 3)) step(rand_dir());
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
         for (int i = 0; i < len; i++) begin
            if (i < len - 1 && $urandom_range(0, 9) == 0) step(rand_dir());
            point(rand_coord(), rand_coord(), i == len - 1);
         end
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
